// ===== hdl/priority_button_debouncer_defines.svh =====
// Assertion macros shared by the debouncer RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PRIORITY_BUTTON_DEBOUNCER_DEFINES_SVH
`define PRIORITY_BUTTON_DEBOUNCER_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication checked on every rising edge outside reset.
`define PBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define PBD_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PBD_ASSERT(label, clk, rst_n, prop, msg)
`define PBD_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hdl/pbd_pkg.sv =====
// Shared types and constants for the priority button debouncer.
// No dependencies; imported by every module of the block.
package pbd_pkg;

    localparam int TIME_W      = 48;
    localparam int DEB_W       = 24;
    localparam int NUM_BUTTONS = 6;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 24'd30000;

    // Expander port bits that carry buttons.
    localparam int EXP_BIT_DOWN = 3;
    localparam int EXP_BIT_BACK = 4;
    localparam int EXP_BIT_LEFT = 5;

    typedef logic [2:0] t_event;

    localparam t_event EV_NONE  = 3'd0;
    localparam t_event EV_PRESS = 3'd1;
    localparam t_event EV_BACK  = 3'd2;
    localparam t_event EV_UP    = 3'd3;
    localparam t_event EV_DOWN  = 3'd4;
    localparam t_event EV_LEFT  = 3'd5;
    localparam t_event EV_RIGHT = 3'd6;

    // Event code of each cell, in priority order.
    localparam t_event BUTTON_CODE [NUM_BUTTONS] =
        '{EV_PRESS, EV_BACK, EV_UP, EV_DOWN, EV_LEFT, EV_RIGHT};

    // Travels from one cell to the next within a poll.
    typedef struct packed {
        logic   blocked;
        t_event code;
    } t_chain;

endpackage

// ===== hdl/pbd_cell.sv =====
// One button cell: holds its accepted level and last change time.
// Depends on pbd_pkg; a row of these forms the priority chain.
module pbd_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_gate,
    input  logic                       i_level,
    input  logic [pbd_pkg::TIME_W-1:0] i_now,
    input  logic [pbd_pkg::DEB_W-1:0]  i_debounce,
    input  pbd_pkg::t_event            i_id,
    input  pbd_pkg::t_chain            i_chain,
    output pbd_pkg::t_chain            o_chain
);
    import pbd_pkg::*;

    logic              r_released;
    logic [TIME_W-1:0] r_last;
    logic              n_released;
    logic [TIME_W-1:0] n_last;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_settled;
    logic              w_accept;
    logic              w_fire;

    // Wrap-around difference: a time going backwards looks like a long wait.
    assign w_elapsed = i_now - r_last;
    assign w_settled = w_elapsed >= {{(TIME_W-DEB_W){1'b0}}, i_debounce};
    assign w_accept  = i_gate && !i_chain.blocked && (i_level != r_released) && w_settled;
    assign w_fire    = w_accept && !i_level;

    assign o_chain.blocked = i_chain.blocked | w_fire;
    assign o_chain.code    = w_fire ? i_id : i_chain.code;

    always_comb begin
        n_released = r_released;
        n_last     = r_last;
        if (i_step && w_accept) begin
            n_released = i_level;
            n_last     = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_released <= 1'b1;
            r_last     <= '0;
        end else begin
            r_released <= n_released;
            r_last     <= n_last;
        end
    end

endmodule

// ===== hdl/pbd_skid.sv =====
// Output register with a skid stage for the event stream.
// Depends on pbd_pkg and the assertion macros in the defines header.
`include "priority_button_debouncer_defines.svh"

module pbd_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pbd_pkg::t_event i_data,
    output logic            o_valid,
    input  logic            i_out_ready,
    output pbd_pkg::t_event o_data
);
    import pbd_pkg::*;

    logic   r_main_valid;
    t_event r_main_data;
    logic   r_skid_valid;
    t_event r_skid_data;
    logic   w_accept;

    assign o_ready  = !r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_data   = r_main_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_main_data  <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_accept;
                r_main_data  <= i_data;
            end
        end else if (w_accept) begin
            // Output is stalled, so the new item parks in the skid stage.
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

    `PBD_NEVER(a_skid_without_main, i_clk, i_rst_n, r_skid_valid && !r_main_valid, "skid holds an item while the output is empty")
    `PBD_ASSERT(a_main_holds, i_clk, i_rst_n, (r_main_valid && !i_out_ready) |=> (r_main_valid && $stable(r_main_data)), "stalled output item changed")
    `PBD_ASSERT(a_skid_captures, i_clk, i_rst_n, (w_accept && r_main_valid && !i_out_ready) |=> (r_skid_valid && r_skid_data == $past(i_data)), "stalled item not parked in skid")
    `PBD_ASSERT(a_skid_drains, i_clk, i_rst_n, (r_skid_valid && i_out_ready) |=> (!r_skid_valid && r_main_data == $past(r_skid_data)), "skid item not moved to output")

endmodule

// ===== hdl/priority_button_debouncer.sv =====
// Priority button debouncer: input unpacking, the row of button cells and
// the output skid register. Depends on pbd_pkg, pbd_cell and pbd_skid.
//
// Unless the input stalls, one poll item is accepted per clock cycle; each
// yields exactly one event item. All six button cells examine a poll in the
// cycle it is accepted; a short priority chain running through the cells
// picks the first accepted press. A two-entry output register (main plus
// skid) lets the input keep flowing while a result waits; the input stalls
// only when both entries are full. The debounce time register may be
// written at any time and resets to 30000 microseconds.
module priority_button_debouncer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbd_pkg::DEB_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [47:0] now_us, [48] press_level, [49] up_level, [50] sda_level,
    // [51] scl_level, [52] expander_valid, [60:53] expander_byte, rest zero
    input  logic [pbd_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] event_res, rest zero
    output logic [pbd_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import pbd_pkg::*;

    logic [DEB_W-1:0]       r_debounce;
    logic [TIME_W-1:0]      w_now;
    logic                   w_press;
    logic                   w_up;
    logic                   w_sda;
    logic                   w_scl;
    logic                   w_exp_valid;
    logic [7:0]             w_exp_byte;
    logic                   w_exp_ok;
    logic [NUM_BUTTONS-1:0] w_level;
    logic [NUM_BUTTONS-1:0] w_gate;
    logic                   w_step;
    t_chain                 w_chain [NUM_BUTTONS+1];
    t_event                 w_event;

    assign w_now       = i_s_tdata[TIME_W-1:0];
    assign w_press     = i_s_tdata[48];
    assign w_up        = i_s_tdata[49];
    assign w_sda       = i_s_tdata[50];
    assign w_scl       = i_s_tdata[51];
    assign w_exp_valid = i_s_tdata[52];
    assign w_exp_byte  = i_s_tdata[60:53];

    // Expander buttons count only with a good sample and an idle bus.
    assign w_exp_ok = w_exp_valid && w_sda && w_scl;

    // Priority order: press, back, up, down, left, right.
    assign w_level = {w_sda, w_exp_byte[EXP_BIT_LEFT], w_exp_byte[EXP_BIT_DOWN],
                      w_up, w_exp_byte[EXP_BIT_BACK], w_press};
    assign w_gate  = {1'b1, w_exp_ok, w_exp_ok, 1'b1, w_exp_ok, 1'b1};

    assign w_step = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce <= i_cfg_wdata;
        end
    end

    assign w_chain[0] = '{blocked: 1'b0, code: EV_NONE};

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
        pbd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (w_step),
            .i_gate     (w_gate[g]),
            .i_level    (w_level[g]),
            .i_now      (w_now),
            .i_debounce (r_debounce),
            .i_id       (BUTTON_CODE[g]),
            .i_chain    (w_chain[g]),
            .o_chain    (w_chain[g+1])
        );
    end

    pbd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_data      (w_chain[NUM_BUTTONS].code),
        .o_valid     (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_data      (w_event)
    );

    assign o_m_tdata = {{(OUT_TDATA_W-$bits(t_event)){1'b0}}, w_event};

endmodule
